### src/iee_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Infix expression evaluator package
// Shared types, codes and widths for the two-stack evaluator.
// ----------------------------------------------------------------------------
package iee_pkg;

  localparam int unsigned STACK_DEPTH = 32;
  localparam int unsigned VALUE_BITS  = 32;
  localparam int unsigned PTR_BITS    = $clog2(STACK_DEPTH);
  localparam int unsigned CNT_BITS    = $clog2(STACK_DEPTH + 1);

  // Token kinds.
  localparam logic [2:0] MODE_NUMBER = 3'd0;
  localparam logic [2:0] MODE_OPER   = 3'd1;
  localparam logic [2:0] MODE_OPEN   = 3'd2;
  localparam logic [2:0] MODE_CLOSE  = 3'd3;
  localparam logic [2:0] MODE_END    = 3'd4;

  // Operator codes as stored on the operator stack.
  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_SUB  = 3'd1;
  localparam logic [2:0] OP_MUL  = 3'd2;
  localparam logic [2:0] OP_DIV  = 3'd3;
  localparam logic [2:0] OP_POW  = 3'd4;
  localparam logic [2:0] OP_OPEN = 3'd5;

  // Status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_DIVZERO   = 2'd1;
  localparam logic [1:0] ST_OVERFLOW  = 2'd2;
  localparam logic [1:0] ST_MALFORMED = 2'd3;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [31:0] number_value;
    logic [2:0]         operator_code;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [1:0]         status;
  } out_beat_t;

  // Request to the arithmetic unit and its answer.
  typedef struct packed {
    logic                  start;
    logic [2:0]            code;
    logic [VALUE_BITS-1:0] x;
    logic [VALUE_BITS-1:0] y;
  } alu_req_t;

  typedef struct packed {
    logic                  done;
    logic                  div_zero;
    logic [VALUE_BITS-1:0] value;
  } alu_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_OP_CHECK,
    S_READ_Y,
    S_READ_X,
    S_ALU_START,
    S_ALU_WAIT,
    S_END_CHECK,
    S_END_READ,
    S_OUTPUT
  } ctl_state_t;

  typedef enum logic [1:0] {
    RD_NONE,
    RD_OPER_LOOP,
    RD_CLOSE_LOOP,
    RD_END_LOOP
  } loop_kind_t;

  function automatic logic [1:0] prec(input logic [2:0] code);
    logic [1:0] p;
    case (code)
      OP_POW:         p = 2'd3;
      OP_MUL, OP_DIV: p = 2'd2;
      default:        p = 2'd1;
    endcase
    return p;
  endfunction

endpackage

### src/iee_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Evaluator arithmetic unit
// Add, subtract and multiply use the A_SIMPLE state; divide is restoring, one quotient
// bit a cycle; power is square and multiply, alternating multiply and square steps.
// ----------------------------------------------------------------------------
module iee_alu (
  input  logic                clk,
  input  logic                rst_n,
  input  iee_pkg::alu_req_t   req,
  output iee_pkg::alu_rsp_t   rsp
);

  localparam int unsigned VB = iee_pkg::VALUE_BITS;
  localparam int unsigned CB = $clog2(VB + 1);

  typedef enum logic [2:0] {
    A_IDLE, A_SIMPLE, A_DIV, A_POW_MUL, A_POW_SQR, A_DONE
  } alu_state_t;

  alu_state_t           state_r, state_nxt;
  logic [VB-1:0]        acc_r, acc_nxt;     // power result or quotient
  logic [VB-1:0]        base_r, base_nxt;   // power base or dividend shift
  logic [VB-1:0]        exp_r, exp_nxt;     // exponent or divisor magnitude
  logic [VB-1:0]        rem_r, rem_nxt;
  logic [CB-1:0]        cnt_r, cnt_nxt;
  logic                 neg_r, neg_nxt;
  logic                 dz_r, dz_nxt;
  logic [VB-1:0]        res_r, res_nxt;
  logic [2:0]           code_r, code_nxt;
  logic [VB-1:0]        x_r, x_nxt, y_r, y_nxt;

  logic [VB-1:0]        ax, ay, mul_res;
  logic [VB:0]          rem_sh, rem_sub;
  logic                 nx, ny;

  always_comb begin
    nx = req.x[VB-1];
    ny = req.y[VB-1];
    ax = nx ? (VB'(0) - req.x) : req.x;
    ay = ny ? (VB'(0) - req.y) : req.y;
    mul_res = VB'(acc_r * base_r);
    rem_sh  = {rem_r, base_r[VB-1]};
    rem_sub = rem_sh - {1'b0, exp_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= A_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    acc_r  <= acc_nxt;
    base_r <= base_nxt;
    exp_r  <= exp_nxt;
    rem_r  <= rem_nxt;
    cnt_r  <= cnt_nxt;
    neg_r  <= neg_nxt;
    dz_r   <= dz_nxt;
    res_r  <= res_nxt;
    code_r <= code_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    acc_nxt   = acc_r;
    base_nxt  = base_r;
    exp_nxt   = exp_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    neg_nxt   = neg_r;
    dz_nxt    = dz_r;
    res_nxt   = res_r;
    code_nxt  = code_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    rsp.done     = 1'b0;
    rsp.div_zero = dz_r;
    rsp.value    = res_r;
    case (state_r)
      A_IDLE: begin
        if (req.start) begin
          code_nxt = req.code;
          x_nxt    = req.x;
          y_nxt    = req.y;
          dz_nxt   = 1'b0;
          case (req.code)
            iee_pkg::OP_DIV: begin
              if (req.y == '0) begin
                dz_nxt    = 1'b1;
                res_nxt   = '0;
                state_nxt = A_DONE;
              end else begin
                base_nxt  = ax;
                exp_nxt   = ay;
                rem_nxt   = '0;
                acc_nxt   = '0;
                neg_nxt   = nx ^ ny;
                cnt_nxt   = CB'(VB);
                state_nxt = A_DIV;
              end
            end
            iee_pkg::OP_POW: begin
              if (ny) begin
                // Negative exponent: truncated reciprocal.
                if (req.x == VB'(1)) begin
                  res_nxt = VB'(1);
                end else if (req.x == {VB{1'b1}}) begin
                  res_nxt = req.y[0] ? {VB{1'b1}} : VB'(1);
                end else if (req.x == '0) begin
                  res_nxt = '0;
                  dz_nxt  = 1'b1;
                end else begin
                  res_nxt = '0;
                end
                state_nxt = A_DONE;
              end else begin
                acc_nxt   = VB'(1);
                base_nxt  = req.x;
                exp_nxt   = req.y;
                state_nxt = A_POW_MUL;
              end
            end
            default: begin
              acc_nxt   = req.x;
              base_nxt  = req.y;
              state_nxt = A_SIMPLE;
            end
          endcase
        end
      end
      A_SIMPLE: begin
        case (code_r)
          iee_pkg::OP_ADD: res_nxt = x_r + y_r;
          iee_pkg::OP_SUB: res_nxt = x_r - y_r;
          default:         res_nxt = mul_res;
        endcase
        state_nxt = A_DONE;
      end
      A_DIV: begin
        // One restoring step per cycle.
        base_nxt = {base_r[VB-2:0], 1'b0};
        if (!rem_sub[VB]) begin
          rem_nxt = rem_sub[VB-1:0];
          acc_nxt = {acc_r[VB-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[VB-1:0];
          acc_nxt = {acc_r[VB-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - CB'(1);
        if (cnt_r == CB'(1)) begin
          state_nxt = A_DONE;
          res_nxt   = neg_r ? (VB'(0) - acc_nxt) : acc_nxt;
        end
      end
      A_POW_MUL: begin
        if (exp_r == '0) begin
          res_nxt   = acc_r;
          state_nxt = A_DONE;
        end else begin
          if (exp_r[0]) acc_nxt = mul_res;
          state_nxt = A_POW_SQR;
        end
      end
      A_POW_SQR: begin
        base_nxt  = VB'(base_r * base_r);
        exp_nxt   = exp_r >> 1;
        state_nxt = A_POW_MUL;
      end
      A_DONE: begin
        rsp.done  = 1'b1;
        state_nxt = A_IDLE;
      end
      default: state_nxt = A_IDLE;
    endcase
  end

endmodule

### src/infix_expression_evaluator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Infix expression evaluator
// Two-stack evaluation of a token stream: value and operator stacks in
// synchronous memories, a sequencer that reduces, and a shared arithmetic unit.
// ----------------------------------------------------------------------------
//  Channel | Direction | Beat
//  in_     | input     | one token (mode, number_value, operator_code)
//  out_    | output    | result and status, once per end token
//
//  Numbers and open parens are pushed directly; operators and close parens
//  first check the top operator, and an end token reduces what is left before the
//  output beat. Each reduction reads y and x, then waits on the arithmetic unit,
//  which iterates for divide and power but not for a zero divisor or negative exponent.
//  Reset is synchronous and clears the counts and status; stacks need no clear.
//  A held result blocks the next token until out_ready.
// ----------------------------------------------------------------------------
module infix_expression_evaluator_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  iee_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output iee_pkg::out_beat_t out_data
);

  localparam int unsigned VB = iee_pkg::VALUE_BITS;
  localparam int unsigned PB = iee_pkg::PTR_BITS;
  localparam int unsigned NB = iee_pkg::CNT_BITS;

  // Stack memories.
  logic [2:0]    op_mem  [iee_pkg::STACK_DEPTH];
  logic [VB-1:0] val_mem [iee_pkg::STACK_DEPTH];
  logic          op_we, val_we;
  logic [PB-1:0] op_waddr, op_raddr, val_waddr, val_raddr;
  logic [2:0]    op_wdata, op_rdata_r;
  logic [VB-1:0] val_wdata, val_rdata_r;

  always_ff @(posedge clk) begin
    if (op_we) op_mem[op_waddr] <= op_wdata;
    op_rdata_r <= op_mem[op_raddr];
  end

  always_ff @(posedge clk) begin
    if (val_we) val_mem[val_waddr] <= val_wdata;
    val_rdata_r <= val_mem[val_raddr];
  end

  iee_pkg::ctl_state_t state_r, state_nxt;
  iee_pkg::loop_kind_t kind_r, kind_nxt;
  iee_pkg::in_beat_t   tok_r, tok_nxt;
  logic [NB-1:0]       opc_r, opc_nxt, valc_r, valc_nxt;
  logic [1:0]          err_r, err_nxt;
  logic [2:0]          top_r, top_nxt;
  logic [VB-1:0]       y_r, y_nxt;
  iee_pkg::out_beat_t  res_r, res_nxt;
  iee_pkg::alu_req_t   alu_req;
  iee_pkg::alu_rsp_t   alu_rsp;

  iee_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req),
    .rsp   (alu_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= iee_pkg::S_IDLE;
      opc_r   <= '0;
      valc_r  <= '0;
      err_r   <= iee_pkg::ST_OK;
    end else begin
      state_r <= state_nxt;
      opc_r   <= opc_nxt;
      valc_r  <= valc_nxt;
      err_r   <= err_nxt;
    end
    kind_r <= kind_nxt;
    tok_r  <= tok_nxt;
    top_r  <= top_nxt;
    y_r    <= y_nxt;
    res_r  <= res_nxt;
  end

  assign out_data = res_r;

  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    tok_nxt   = tok_r;
    opc_nxt   = opc_r;
    valc_nxt  = valc_r;
    err_nxt   = err_r;
    top_nxt   = top_r;
    y_nxt     = y_r;
    res_nxt   = res_r;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    op_we     = 1'b0;
    val_we    = 1'b0;
    op_waddr  = opc_r[PB-1:0];
    op_wdata  = iee_pkg::OP_OPEN;
    val_waddr = valc_r[PB-1:0];
    val_wdata = tok_r.number_value;
    op_raddr  = PB'(opc_r - NB'(1));
    val_raddr = PB'(valc_r - NB'(1));
    alu_req.start = 1'b0;
    alu_req.code  = top_r;
    alu_req.x     = val_rdata_r;
    alu_req.y     = y_r;
    case (state_r)
      iee_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          tok_nxt   = in_data;
          state_nxt = iee_pkg::S_DISPATCH;
        end
      end
      iee_pkg::S_DISPATCH: begin
        // The top operator read is issued here for every loop kind.
        state_nxt = iee_pkg::S_IDLE;
        if (tok_r.mode == iee_pkg::MODE_END) begin
          kind_nxt  = iee_pkg::RD_END_LOOP;
          state_nxt = iee_pkg::S_END_CHECK;
        end else if (err_r == iee_pkg::ST_OK) begin
          case (tok_r.mode)
            iee_pkg::MODE_NUMBER: begin
              if (valc_r >= NB'(iee_pkg::STACK_DEPTH)) begin
                err_nxt = iee_pkg::ST_OVERFLOW;
              end else begin
                val_we   = 1'b1;
                valc_nxt = valc_r + NB'(1);
              end
            end
            iee_pkg::MODE_OPER: begin
              if (tok_r.operator_code > iee_pkg::OP_POW) begin
                err_nxt = iee_pkg::ST_MALFORMED;
              end else begin
                kind_nxt  = iee_pkg::RD_OPER_LOOP;
                state_nxt = iee_pkg::S_OP_CHECK;
              end
            end
            iee_pkg::MODE_OPEN: begin
              if (opc_r >= NB'(iee_pkg::STACK_DEPTH)) begin
                err_nxt = iee_pkg::ST_OVERFLOW;
              end else begin
                op_we   = 1'b1;
                opc_nxt = opc_r + NB'(1);
              end
            end
            iee_pkg::MODE_CLOSE: begin
              kind_nxt  = iee_pkg::RD_CLOSE_LOOP;
              state_nxt = iee_pkg::S_OP_CHECK;
            end
            default: state_nxt = iee_pkg::S_IDLE;
          endcase
        end
      end
      iee_pkg::S_OP_CHECK: begin
        // op_rdata_r holds the top operator read in the previous cycle.
        top_nxt   = op_rdata_r;
        state_nxt = iee_pkg::S_IDLE;
        if (kind_r == iee_pkg::RD_OPER_LOOP) begin
          if (opc_r != '0 && op_rdata_r != iee_pkg::OP_OPEN &&
              iee_pkg::prec(tok_r.operator_code) <= iee_pkg::prec(op_rdata_r)) begin
            opc_nxt   = opc_r - NB'(1);
            state_nxt = iee_pkg::S_READ_Y;
          end else if (opc_r >= NB'(iee_pkg::STACK_DEPTH)) begin
            err_nxt = iee_pkg::ST_OVERFLOW;
          end else begin
            op_we    = 1'b1;
            op_wdata = tok_r.operator_code;
            opc_nxt  = opc_r + NB'(1);
          end
        end else begin
          if (opc_r == '0) begin
            err_nxt = iee_pkg::ST_MALFORMED;
          end else if (op_rdata_r == iee_pkg::OP_OPEN) begin
            opc_nxt = opc_r - NB'(1);
          end else begin
            opc_nxt   = opc_r - NB'(1);
            state_nxt = iee_pkg::S_READ_Y;
          end
        end
        if (state_nxt == iee_pkg::S_READ_Y && valc_r < NB'(2)) begin
          err_nxt   = iee_pkg::ST_MALFORMED;
          state_nxt = (kind_r == iee_pkg::RD_END_LOOP) ? iee_pkg::S_OUTPUT
                                                        : iee_pkg::S_IDLE;
        end
      end
      iee_pkg::S_READ_Y: begin
        // Read address is valc-1 (y); next cycle reads x.
        state_nxt = iee_pkg::S_READ_X;
      end
      iee_pkg::S_READ_X: begin
        y_nxt     = val_rdata_r;
        val_raddr = PB'(valc_r - NB'(2));
        state_nxt = iee_pkg::S_ALU_START;
      end
      iee_pkg::S_ALU_START: begin
        alu_req.start = 1'b1;
        state_nxt     = iee_pkg::S_ALU_WAIT;
      end
      iee_pkg::S_ALU_WAIT: begin
        if (alu_rsp.done) begin
          valc_nxt  = valc_r - NB'(1);
          val_we    = 1'b1;
          val_waddr = PB'(valc_r - NB'(2));
          val_wdata = alu_rsp.value;
          if (alu_rsp.div_zero) begin
            err_nxt = iee_pkg::ST_DIVZERO;
          end
          if (alu_rsp.div_zero && kind_r != iee_pkg::RD_END_LOOP) begin
            state_nxt = iee_pkg::S_IDLE;
          end else if (kind_r == iee_pkg::RD_END_LOOP) begin
            state_nxt = iee_pkg::S_END_CHECK;
          end else begin
            state_nxt = iee_pkg::S_DISPATCH;
          end
        end
      end
      iee_pkg::S_END_CHECK: begin
        // Issue top operator read; decide next cycle.
        if (err_r != iee_pkg::ST_OK) begin
          state_nxt = iee_pkg::S_OUTPUT;
        end else if (opc_r == '0) begin
          if (valc_r != NB'(1)) begin
            err_nxt = iee_pkg::ST_MALFORMED;
          end
          val_raddr = '0;
          state_nxt = iee_pkg::S_END_READ;
        end else begin
          state_nxt = iee_pkg::S_END_READ;
        end
      end
      iee_pkg::S_END_READ: begin
        if (err_r != iee_pkg::ST_OK) begin
          state_nxt = iee_pkg::S_OUTPUT;
        end else if (opc_r == '0) begin
          state_nxt = iee_pkg::S_OUTPUT;
        end else if (op_rdata_r == iee_pkg::OP_OPEN) begin
          err_nxt   = iee_pkg::ST_MALFORMED;
          state_nxt = iee_pkg::S_OUTPUT;
        end else if (valc_r < NB'(2)) begin
          err_nxt   = iee_pkg::ST_MALFORMED;
          state_nxt = iee_pkg::S_OUTPUT;
        end else begin
          top_nxt   = op_rdata_r;
          opc_nxt   = opc_r - NB'(1);
          state_nxt = iee_pkg::S_READ_Y;
        end
        res_nxt.status       = err_nxt;
        res_nxt.result_value = (err_nxt == iee_pkg::ST_OK) ? val_rdata_r : '0;
      end
      iee_pkg::S_OUTPUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          opc_nxt   = '0;
          valc_nxt  = '0;
          err_nxt   = iee_pkg::ST_OK;
          state_nxt = iee_pkg::S_IDLE;
        end
      end
      default: state_nxt = iee_pkg::S_IDLE;
    endcase
    // Error path into output must carry the final status.
    if (state_r != iee_pkg::S_END_READ && state_r != iee_pkg::S_OUTPUT &&
        state_nxt == iee_pkg::S_OUTPUT) begin
      res_nxt.status       = err_nxt;
      res_nxt.result_value = '0;
    end
  end

endmodule
